// File: hw/rtl/scm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_pkg
// Shared constants, types and controller states of the sigma-clipped mean
// filter.
// ----------------------------------------------------------------------------
package scm_pkg;

  // Sample store geometry.
  localparam int MAX_SAMPLES = 64;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int SAMPLE_W    = 24;

  // Shift-add multiplier: 64-bit multiplicand, 32-bit multiplier.
  localparam int MUL_A_W     = 64;
  localparam int MUL_B_W     = 32;
  localparam int MUL_STEP_W  = $clog2(MUL_B_W);

  // Restoring divider: dividend width and step counter.
  localparam int DIV_W       = 38;
  localparam int DIV_STEP_W  = $clog2(DIV_W);

  // Fixed scale factors of the results.
  localparam int CONF_SCALE  = 100;
  localparam int MEAN_FRAC   = 8;

  typedef struct packed {
    logic               go;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] num;
    logic [CNT_W-1:0] den;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_G_CLR,
    ST_G_RD,
    ST_G_ACC,
    ST_C_CHECK,
    ST_C_NN1,
    ST_C_NQ,
    ST_C_SS,
    ST_C_LL,
    ST_C_LLN,
    ST_R_CLR,
    ST_R_RD,
    ST_R_DAT,
    ST_R_NX,
    ST_R_DIV,
    ST_R_TT,
    ST_R_TTN,
    ST_F_MEAN,
    ST_F_CONF,
    ST_F_OUT
  } state_t;

endpackage

// File: hw/rtl/scm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scm_store (
  input  logic                          clk,
  input  logic                          we,
  input  logic [scm_pkg::ADDR_W-1:0]    waddr,
  input  logic [scm_pkg::SAMPLE_W-1:0]  wdata,
  input  logic [scm_pkg::ADDR_W-1:0]    raddr,
  output logic [scm_pkg::SAMPLE_W-1:0]  rdata
);
  import scm_pkg::*;

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/scm_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_mul
// Shift-add multiplier, one multiplier bit per cycle. The product is valid
// in the cycle that done is high and holds until the next request.
// ----------------------------------------------------------------------------
module scm_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  scm_pkg::mul_req_t           req,
  output logic                        done,
  output logic [scm_pkg::MUL_A_W-1:0] prod
);
  import scm_pkg::*;

  logic                  run;
  logic [MUL_STEP_W-1:0] cnt;
  logic [MUL_A_W-1:0]    aa;
  logic [MUL_B_W-1:0]    bb;

  // Control: run flag and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
      end else if (run && cnt == MUL_STEP_W'(MUL_B_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set multiplier bit.
  always_ff @(posedge clk) begin
    if (req.go) begin
      aa   <= req.a;
      bb   <= req.b;
      prod <= '0;
      cnt  <= '0;
    end else if (run) begin
      if (bb[0]) begin
        prod <= prod + aa;
      end
      aa  <= aa << 1;
      bb  <= bb >> 1;
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: hw/rtl/scm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_div
// Restoring divider, one quotient bit per cycle, for a small divisor.
// The quotient is valid in the cycle that done is high.
// ----------------------------------------------------------------------------
module scm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  scm_pkg::div_req_t         req,
  output logic                      done,
  output logic [scm_pkg::DIV_W-1:0] quo
);
  import scm_pkg::*;

  logic                  run;
  logic [DIV_STEP_W-1:0] cnt;
  logic [CNT_W-1:0]      den;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W:0]        trial;
  logic                  fits;

  // Partial remainder stays below the divisor, so it fits in CNT_W bits.
  assign trial = {rem, quo[DIV_W-1]};
  assign fits  = trial >= {1'b0, den};

  // Control: run flag and completion strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        run <= 1'b1;
      end else if (run && cnt == DIV_STEP_W'(DIV_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: shift in one dividend bit, subtract when the divisor fits.
  always_ff @(posedge clk) begin
    if (req.go) begin
      quo <= req.num;
      den <= req.den;
      rem <= '0;
      cnt <= '0;
    end else if (run) begin
      rem <= fits ? CNT_W'(trial - {1'b0, den}) : CNT_W'(trial);
      quo <= {quo[DIV_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// File: hw/rtl/sigma_clipped_mean_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sigma_clipped_mean_filter
// Collects a set of 24-bit samples and returns the sigma-clipped mean.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while busy is low; a sample without the
// last mark leaves busy low. The sample with the last mark starts the
// clipping rounds and busy stays high until the single result strobe. Each
// round reads the store once to gather sums of the kept samples; with fewer
// than two it ends with the error status. Else it uses the shared shift-add
// multiplier for the spread and limit and, unless the limit test ends the
// rounds, reads the store again and runs each kept sample through the
// multiplier and divider. The divider then gives the mean and percentage.
// The result is on the ports for exactly one cycle, marked by result_valid;
// the receiver cannot stall it.
// ----------------------------------------------------------------------------
module sigma_clipped_mean_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [scm_pkg::SAMPLE_W-1:0] sample,
  input  logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [scm_pkg::SAMPLE_W-1:0] cfg_data,
  output logic                         result_valid,
  output logic signed [31:0]           mean_q8,
  output logic [6:0]                   confidence,
  output logic [scm_pkg::CNT_W-1:0]    kept_count,
  output logic                         status
);
  import scm_pkg::*;

  state_t state, state_next;

  logic                  pend;
  logic [SAMPLE_W-1:0]   dev_limit;
  logic [CNT_W-1:0]      loaded;
  logic [MAX_SAMPLES-1:0] keep;
  logic [CNT_W-1:0]      idx;

  logic signed [30:0]    s_sum;
  logic [52:0]           q_sum;
  logic [CNT_W-1:0]      n;
  logic [11:0]           nn1;
  logic [63:0]           nq;
  logic [63:0]           spread;
  logic [47:0]           ll;
  logic                  removed;
  logic                  xneg;
  logic [SAMPLE_W-1:0]   xabs_r;
  logic [31:0]           dabs_r;
  logic [31:0]           t;
  logic [63:0]           tt;
  logic signed [31:0]    mean_r;
  logic [6:0]            conf_r;
  logic                  status_r;

  logic                  store_we;
  logic [SAMPLE_W-1:0]   rdata;
  logic [SAMPLE_W-1:0]   xabs;
  logic [47:0]           xsq;
  logic [30:0]           sabs;
  logic signed [32:0]    nx;
  logic signed [32:0]    dval;
  logic                  accept;
  logic                  is_mul, is_div;
  logic                  mul_done, div_done;
  logic [MUL_A_W-1:0]    prod;
  logic [DIV_W-1:0]      quo;
  mul_req_t              mul_req;
  div_req_t              div_req;

  assign accept    = start && !busy;
  assign busy      = state != ST_LOAD;
  assign cfg_ready = !busy;
  assign store_we  = accept && loaded < CNT_W'(MAX_SAMPLES);

  // Magnitudes of the sample read back and of the running sum.
  assign xabs = rdata[SAMPLE_W-1] ? SAMPLE_W'(~rdata + 1'b1) : rdata;
  assign sabs = s_sum[30] ? 31'(-s_sum) : 31'(s_sum);

  // Square of the sample magnitude at its full width.
  assign xsq = xabs * xabs;

  // Scaled distance of a sample from the mean: n*x - S.
  assign nx   = $signed({1'b0, prod[31:0]});
  assign dval = (xneg ? -nx : nx) - 33'(s_sum);

  scm_store u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (loaded[ADDR_W-1:0]),
    .wdata (sample),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  scm_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .done (mul_done),
    .prod (prod)
  );

  scm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (quo)
  );

  // Operand selection for the shared arithmetic units.
  always_comb begin
    is_mul = state inside {ST_C_NN1, ST_C_NQ, ST_C_SS, ST_C_LL, ST_C_LLN,
                           ST_R_NX, ST_R_TT, ST_R_TTN};
    is_div = state inside {ST_R_DIV, ST_F_MEAN, ST_F_CONF};
    mul_req.go = is_mul && !pend;
    div_req.go = is_div && !pend;
    mul_req.a  = '0;
    mul_req.b  = '0;
    div_req.num = '0;
    div_req.den = n;
    case (state)
      ST_C_NN1: begin
        mul_req.a = MUL_A_W'(n);
        mul_req.b = MUL_B_W'(n - 1'b1);
      end
      ST_C_NQ: begin
        mul_req.a = MUL_A_W'(q_sum);
        mul_req.b = MUL_B_W'(n);
      end
      ST_C_SS: begin
        mul_req.a = MUL_A_W'(sabs);
        mul_req.b = MUL_B_W'(sabs);
      end
      ST_C_LL: begin
        mul_req.a = MUL_A_W'(dev_limit);
        mul_req.b = MUL_B_W'(dev_limit);
      end
      ST_C_LLN: begin
        mul_req.a = MUL_A_W'(ll);
        mul_req.b = MUL_B_W'(nn1);
      end
      ST_R_NX: begin
        mul_req.a = MUL_A_W'(xabs_r);
        mul_req.b = MUL_B_W'(n);
      end
      ST_R_TT: begin
        mul_req.a = MUL_A_W'(t);
        mul_req.b = t;
      end
      ST_R_TTN: begin
        mul_req.a = tt;
        mul_req.b = MUL_B_W'(nn1);
      end
      ST_R_DIV: begin
        div_req.num = DIV_W'(dabs_r);
      end
      ST_F_MEAN: begin
        div_req.num = {sabs[29:0], MEAN_FRAC'(0)};
      end
      ST_F_CONF: begin
        div_req.num = DIV_W'(n) * DIV_W'(CONF_SCALE);
        div_req.den = loaded;
      end
      default: begin
      end
    endcase
  end

  // Next-state logic of the round sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (accept && last) state_next = ST_G_CLR;
      end
      ST_G_CLR:   state_next = ST_G_RD;
      ST_G_RD:    state_next = (idx == loaded) ? ST_C_CHECK : ST_G_ACC;
      ST_G_ACC:   state_next = ST_G_RD;
      ST_C_CHECK: state_next = (n < CNT_W'(2)) ? ST_F_OUT : ST_C_NN1;
      ST_C_NN1: begin
        if (mul_done) state_next = ST_C_NQ;
      end
      ST_C_NQ: begin
        if (mul_done) state_next = ST_C_SS;
      end
      ST_C_SS: begin
        if (mul_done) state_next = ST_C_LL;
      end
      ST_C_LL: begin
        if (mul_done) state_next = ST_C_LLN;
      end
      ST_C_LLN: begin
        if (mul_done) begin
          if (spread < prod || n <= CNT_W'(2)) state_next = ST_F_MEAN;
          else state_next = ST_R_CLR;
        end
      end
      ST_R_CLR: state_next = ST_R_RD;
      ST_R_RD: begin
        if (idx == loaded) state_next = removed ? ST_G_CLR : ST_F_MEAN;
        else state_next = ST_R_DAT;
      end
      ST_R_DAT: state_next = keep[idx[ADDR_W-1:0]] ? ST_R_NX : ST_R_RD;
      ST_R_NX: begin
        if (mul_done) state_next = ST_R_DIV;
      end
      ST_R_DIV: begin
        if (div_done) state_next = ST_R_TT;
      end
      ST_R_TT: begin
        if (mul_done) state_next = ST_R_TTN;
      end
      ST_R_TTN: begin
        if (mul_done) state_next = ST_R_RD;
      end
      ST_F_MEAN: begin
        if (div_done) state_next = ST_F_CONF;
      end
      ST_F_CONF: begin
        if (div_done) state_next = ST_F_OUT;
      end
      ST_F_OUT: state_next = ST_LOAD;
      default:  state_next = ST_LOAD;
    endcase
  end

  // Control registers: state, unit handshake, set count, keep mask, limit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      pend      <= 1'b0;
      dev_limit <= '0;
      loaded    <= '0;
      keep      <= '1;
    end else begin
      state <= state_next;
      if (mul_req.go || div_req.go) begin
        pend <= 1'b1;
      end else if (mul_done || div_done) begin
        pend <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        dev_limit <= cfg_data;
      end
      if (store_we) begin
        loaded <= loaded + 1'b1;
      end
      if (state == ST_R_TTN && mul_done && !(prod < spread)) begin
        keep[idx[ADDR_W-1:0]] <= 1'b0;
      end
      if (state == ST_F_OUT) begin
        loaded <= '0;
        keep   <= '1;
      end
    end
  end

  // Datapath registers of the rounds.
  always_ff @(posedge clk) begin
    case (state)
      ST_G_CLR: begin
        idx   <= '0;
        s_sum <= '0;
        q_sum <= '0;
        n     <= '0;
      end
      ST_G_ACC: begin
        if (keep[idx[ADDR_W-1:0]]) begin
          s_sum <= s_sum + 31'($signed(rdata));
          q_sum <= q_sum + 53'(xsq);
          n     <= n + 1'b1;
        end
        idx <= idx + 1'b1;
      end
      ST_C_CHECK: begin
        status_r <= n < CNT_W'(2);
        mean_r   <= '0;
        conf_r   <= '0;
      end
      ST_C_NN1: begin
        if (mul_done) nn1 <= prod[11:0];
      end
      ST_C_NQ: begin
        if (mul_done) nq <= prod;
      end
      ST_C_SS: begin
        if (mul_done) spread <= nq - prod;
      end
      ST_C_LL: begin
        if (mul_done) ll <= prod[47:0];
      end
      ST_R_CLR: begin
        idx     <= '0;
        removed <= 1'b0;
      end
      ST_R_DAT: begin
        xneg   <= rdata[SAMPLE_W-1];
        xabs_r <= xabs;
        if (!keep[idx[ADDR_W-1:0]]) idx <= idx + 1'b1;
      end
      ST_R_NX: begin
        if (mul_done) dabs_r <= dval[32] ? 32'(-dval) : 32'(dval);
      end
      ST_R_DIV: begin
        if (div_done) t <= quo[31:0];
      end
      ST_R_TT: begin
        if (mul_done) tt <= prod;
      end
      ST_R_TTN: begin
        if (mul_done) begin
          if (!(prod < spread)) removed <= 1'b1;
          idx <= idx + 1'b1;
        end
      end
      ST_F_MEAN: begin
        if (div_done) begin
          mean_r <= s_sum[30] ? -$signed(quo[31:0]) : $signed(quo[31:0]);
        end
      end
      ST_F_CONF: begin
        if (div_done) conf_r <= quo[6:0];
      end
      default: begin
      end
    endcase
  end

  // Result ports.
  assign result_valid = state == ST_F_OUT;
  assign mean_q8      = mean_r;
  assign confidence   = conf_r;
  assign kept_count   = n;
  assign status       = status_r;

endmodule

// File: hw/rtl/scm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scm_checker
// Port-level checks of the sigma-clipped mean filter, bound to the top level.
// ----------------------------------------------------------------------------
module scm_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         last,
  input logic                         result_valid,
  input logic signed [31:0]           mean_q8,
  input logic [6:0]                   confidence,
  input logic [scm_pkg::CNT_W-1:0]    kept_count,
  input logic                         status
);
  import scm_pkg::*;

  // A result comes only at the end of processing, never back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("two result strobes in a row");

  // The result is shown while the block is still busy with the set.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result strobe while idle");

  // A failed set reports zero mean and zero confidence.
  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && status) |-> (mean_q8 == 0 && confidence == 0))
    else $error("error result with nonzero fields");

  // A good set keeps at least two samples.
  a_ok_kept: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !status) |-> kept_count >= CNT_W'(2))
    else $error("good result with fewer than two samples");

  // A sample without the last mark leaves the block ready.
  a_load_ready: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> !busy)
    else $error("block busy after an ordinary sample");

endmodule

bind sigma_clipped_mean_filter scm_checker u_scm_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .last         (last),
  .result_valid (result_valid),
  .mean_q8      (mean_q8),
  .confidence   (confidence),
  .kept_count   (kept_count),
  .status       (status)
);
